/* hdl/bgv_pkg.sv */
// Shared types and constants for the counting Bloom vector engine.
// No dependencies; all other files of the block but tb/tb_if.sv refer to it by scoped name.
`default_nettype none
package bgv_pkg;

    localparam int unsigned VectorSize = 256;
    localparam int unsigned IndexWidth = $clog2(VectorSize);
    localparam int unsigned CountWidth = 8;
    localparam int unsigned SumWidth   = 16;
    localparam int unsigned SeedWidth  = 32;
    localparam int unsigned LcgWidth   = 64;
    localparam int unsigned HashWidth  = 5;
    localparam int unsigned CfgIdxWidth = 1;
    localparam int unsigned CfgDataWidth = 8;

    localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;
    localparam logic [SumWidth-1:0] SUM_MAX = '1;

    localparam logic [HashWidth-1:0]  HASH_COUNT_RESET = 5'd4;
    localparam logic [CountWidth-1:0] FILL_LEVEL_RESET = 8'd255;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_MERGE = 2'd1,
        OP_DEGRADE = 2'd2,
        OP_PROB  = 2'd3
    } op_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_HASH_COUNT = 1'b0,
        CFG_FILL_LEVEL = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_HASH_LO,
        ST_HASH_MID,
        ST_HASH_HI
    } state_t;

    typedef enum logic [1:0] {
        PH_NONE,
        PH_LO,
        PH_MID,
        PH_HI
    } hash_phase_t;

    typedef struct packed {
        logic        load;
        hash_phase_t phase;
    } hash_ctrl_t;

endpackage
`default_nettype wire

/* hdl/bgv_if.sv */
// Valid/ready channel interfaces for the item and result streams.
// Depends on bgv_pkg for field widths.
`default_nettype none
interface bgv_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         operation;
    logic [bgv_pkg::SeedWidth-1:0]      node_id;
    logic [bgv_pkg::IndexWidth-1:0]     element_index;
    logic [bgv_pkg::CountWidth-1:0]     element_value;
    logic                               last_element;

    modport source (output valid, operation, node_id, element_index, element_value,
                    last_element, input ready);
    modport sink (input valid, operation, node_id, element_index, element_value,
                  last_element, output ready);
endinterface

interface bgv_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [bgv_pkg::CountWidth-1:0]     stored_value;
    logic [bgv_pkg::SumWidth-1:0]       probability_sum;
    logic                               sum_valid;

    modport source (output valid, stored_value, probability_sum, sum_valid, input ready);
    modport sink (input valid, stored_value, probability_sum, sum_valid, output ready);
endinterface
`default_nettype wire

/* hdl/bgv_counter_ram.sv */
// Counter vector: synchronous memory with registered read and per-entry valid bits.
// Depends on bgv_pkg. A cleared or never-written entry reads as zero.
`default_nettype none
module bgv_counter_ram (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           clear,
    input  wire logic                           rd_en,
    input  wire logic [bgv_pkg::IndexWidth-1:0] rd_addr,
    input  wire logic                           wr_en,
    input  wire logic [bgv_pkg::IndexWidth-1:0] wr_addr,
    input  wire logic [bgv_pkg::CountWidth-1:0] wr_data,
    output logic [bgv_pkg::CountWidth-1:0]      rd_data
);

    logic [bgv_pkg::CountWidth-1:0] mem [bgv_pkg::VectorSize];
    logic [bgv_pkg::VectorSize-1:0] valid_reg;
    logic [bgv_pkg::CountWidth-1:0] q_reg;
    logic                           vq_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // Track written entries; clear drops the whole vector at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vq_reg    <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vq_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = vq_reg ? q_reg : '0;

endmodule
`default_nettype wire

/* hdl/bgv_hash_unit.sv */
// LCG hash unit: one 32x32 multiplier shared over three phases per step.
// Depends on bgv_pkg for constants and the hash control struct.
`default_nettype none
module bgv_hash_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bgv_pkg::hash_ctrl_t            ctrl,
    input  wire logic [bgv_pkg::SeedWidth-1:0]  seed,
    output logic [bgv_pkg::IndexWidth-1:0]      hash_addr
);

    logic [bgv_pkg::LcgWidth-1:0] lcg_reg, lcg_next;
    logic [bgv_pkg::LcgWidth-1:0] part_reg, part_next;
    logic [31:0]                  mul_a, mul_b;
    logic [63:0]                  prod;
    logic [bgv_pkg::LcgWidth-1:0] step_value;

    // Pick multiplier operands by phase: low*low, low*high, high*low
    always_comb
    begin
        mul_a = lcg_reg[31:0];
        mul_b = bgv_pkg::LCG_MUL[31:0];
        case (ctrl.phase)
            bgv_pkg::PH_MID: mul_b = bgv_pkg::LCG_MUL[63:32];
            bgv_pkg::PH_HI:  mul_a = lcg_reg[63:32];
            default:         mul_b = bgv_pkg::LCG_MUL[31:0];
        endcase
    end

    assign prod = mul_a * mul_b;
    assign step_value = {part_reg[63:32] + prod[31:0], part_reg[31:0]} + bgv_pkg::LCG_ADD;
    assign hash_addr = step_value[32 +: bgv_pkg::IndexWidth];

    // Accumulate partial products, finish the step in the high phase
    always_comb
    begin
        lcg_next  = lcg_reg;
        part_next = part_reg;
        if (ctrl.load)
        begin
            lcg_next = {{(bgv_pkg::LcgWidth - bgv_pkg::SeedWidth){1'b0}}, seed};
        end
        else
        begin
            case (ctrl.phase)
                bgv_pkg::PH_LO:  part_next = prod;
                bgv_pkg::PH_MID: part_next = {part_reg[63:32] + prod[31:0], part_reg[31:0]};
                bgv_pkg::PH_HI:  lcg_next = step_value;
                default:         part_next = part_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg <= '0;
        end
        else
        begin
            lcg_reg <= lcg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
    end

endmodule
`default_nettype wire

/* hdl/bloom_gradient_vector_engine_core.sv */
// Counting Bloom vector engine: top level with sequencer and result register.
// Depends on bgv_pkg, bgv_if, bgv_counter_ram and bgv_hash_unit.
// Merge, degrade and probability items do a memory read, then an update.
// Init clears the vector, then runs hash_count LCG steps of three multiplier phases each.
// Results are registered at the end of the update; the next item is taken once that register is free or draining.
// Reset clears the vector valid bits, sum and LCG state at once; registers go to 4 and 255.
`default_nettype none
module bloom_gradient_vector_engine_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    bgv_req_if.sink                                 request,
    bgv_rsp_if.source                               response,
    input  wire logic                               cfg_we,
    input  wire logic [bgv_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  wire logic [bgv_pkg::CfgDataWidth-1:0]   cfg_data
);

    bgv_pkg::state_t                  state_reg, state_next;
    logic [bgv_pkg::HashWidth-1:0]    hash_count_reg;
    logic [bgv_pkg::CountWidth-1:0]   fill_level_reg;
    logic [bgv_pkg::HashWidth-1:0]    step_reg, step_next;
    logic [bgv_pkg::SumWidth-1:0]     sum_reg, sum_next;
    bgv_pkg::op_t                     op_reg;
    logic [bgv_pkg::IndexWidth-1:0]   idx_reg;
    logic [bgv_pkg::CountWidth-1:0]   val_reg;
    logic                             last_reg;

    logic                             out_valid_reg;
    logic [bgv_pkg::CountWidth-1:0]   out_stored_reg, out_stored_next;
    logic [bgv_pkg::SumWidth-1:0]     out_sum_reg, out_sum_next;
    logic                             out_flag_reg, out_flag_next;
    logic                             out_load;

    logic                             accept;
    logic                             is_init;
    logic                             hash_last;
    logic                             ram_wr_en;
    logic [bgv_pkg::IndexWidth-1:0]   ram_wr_addr;
    logic [bgv_pkg::CountWidth-1:0]   ram_wr_data;
    logic [bgv_pkg::CountWidth-1:0]   ram_rd_data;
    logic [bgv_pkg::IndexWidth-1:0]   hash_addr;
    bgv_pkg::hash_ctrl_t              hash_ctrl;
    logic [bgv_pkg::SumWidth:0]       sum_wide;

    // Take an item when idle and the result slot is free or draining
    assign request.ready = (state_reg == bgv_pkg::ST_IDLE)
                           && (!out_valid_reg || response.ready);
    assign accept    = request.valid && request.ready;
    assign is_init   = (bgv_pkg::op_t'(request.operation) == bgv_pkg::OP_INIT);
    assign hash_last = (step_reg == hash_count_reg - 1'b1);

    bgv_counter_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (accept && is_init),
        .rd_en   (accept),
        .rd_addr (request.element_index),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    bgv_hash_unit u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (hash_ctrl),
        .seed      (request.node_id),
        .hash_addr (hash_addr)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bgv_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!is_init)
                    begin
                        state_next = bgv_pkg::ST_ACCESS;
                    end
                    else if (hash_count_reg != '0)
                    begin
                        state_next = bgv_pkg::ST_HASH_LO;
                    end
                end
            end
            bgv_pkg::ST_ACCESS:   state_next = bgv_pkg::ST_IDLE;
            bgv_pkg::ST_HASH_LO:  state_next = bgv_pkg::ST_HASH_MID;
            bgv_pkg::ST_HASH_MID: state_next = bgv_pkg::ST_HASH_HI;
            bgv_pkg::ST_HASH_HI:
            begin
                state_next = hash_last ? bgv_pkg::ST_IDLE : bgv_pkg::ST_HASH_LO;
            end
            default:              state_next = bgv_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls and result values per state
    always_comb
    begin
        hash_ctrl.load  = accept && is_init;
        hash_ctrl.phase = bgv_pkg::PH_NONE;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = ram_rd_data;
        step_next       = step_reg;
        sum_next        = sum_reg;
        out_load        = 1'b0;
        out_stored_next = '0;
        out_sum_next    = '0;
        out_flag_next   = 1'b0;
        sum_wide        = {1'b0, sum_reg} + {{(bgv_pkg::SumWidth + 1
                          - bgv_pkg::CountWidth){1'b0}}, ram_rd_data};
        case (state_reg)
            bgv_pkg::ST_IDLE:
            begin
                if (accept && is_init)
                begin
                    step_next = '0;
                    out_load  = (hash_count_reg == '0);
                end
            end
            bgv_pkg::ST_ACCESS:
            begin
                out_load = 1'b1;
                case (op_reg)
                    bgv_pkg::OP_MERGE:
                    begin
                        ram_wr_en = 1'b1;
                        if (val_reg > ram_rd_data)
                        begin
                            ram_wr_data = val_reg;
                        end
                        out_stored_next = ram_wr_data;
                    end
                    bgv_pkg::OP_DEGRADE:
                    begin
                        ram_wr_en = 1'b1;
                        if (val_reg != '0 && ram_rd_data != '0)
                        begin
                            ram_wr_data = ram_rd_data - 1'b1;
                        end
                        out_stored_next = ram_wr_data;
                    end
                    bgv_pkg::OP_PROB:
                    begin
                        out_stored_next = ram_rd_data;
                        if (val_reg != '0)
                        begin
                            sum_next = sum_wide[bgv_pkg::SumWidth]
                                       ? bgv_pkg::SUM_MAX : sum_wide[bgv_pkg::SumWidth-1:0];
                        end
                        if (last_reg)
                        begin
                            out_sum_next  = sum_next;
                            out_flag_next = 1'b1;
                            sum_next      = '0;
                        end
                    end
                    default: out_stored_next = '0;
                endcase
            end
            bgv_pkg::ST_HASH_LO:  hash_ctrl.phase = bgv_pkg::PH_LO;
            bgv_pkg::ST_HASH_MID: hash_ctrl.phase = bgv_pkg::PH_MID;
            bgv_pkg::ST_HASH_HI:
            begin
                hash_ctrl.phase = bgv_pkg::PH_HI;
                ram_wr_en       = 1'b1;
                ram_wr_addr     = hash_addr;
                ram_wr_data     = fill_level_reg;
                step_next       = step_reg + 1'b1;
                out_load        = hash_last;
            end
            default: out_load = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bgv_pkg::ST_IDLE;
            step_reg       <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
            hash_count_reg <= bgv_pkg::HASH_COUNT_RESET;
            fill_level_reg <= bgv_pkg::FILL_LEVEL_RESET;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sum_reg   <= sum_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (bgv_pkg::cfg_idx_t'(cfg_index))
                    bgv_pkg::CFG_HASH_COUNT:
                        hash_count_reg <= cfg_data[bgv_pkg::HashWidth-1:0];
                    bgv_pkg::CFG_FILL_LEVEL:
                        fill_level_reg <= cfg_data;
                    default: fill_level_reg <= fill_level_reg;
                endcase
            end
        end
    end

    // Hold item fields and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= bgv_pkg::op_t'(request.operation);
            idx_reg  <= request.element_index;
            val_reg  <= request.element_value;
            last_reg <= request.last_element;
        end
        if (out_load)
        begin
            out_stored_reg <= out_stored_next;
            out_sum_reg    <= out_sum_next;
            out_flag_reg   <= out_flag_next;
        end
    end

    assign response.valid           = out_valid_reg;
    assign response.stored_value    = out_stored_reg;
    assign response.probability_sum = out_sum_reg;
    assign response.sum_valid       = out_flag_reg;

    // Memory is written only while an item is at work
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bgv_pkg::ST_IDLE) |-> !ram_wr_en)
        else $error("counter write while idle");

    // A result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || response.ready))
        else $error("result register overwritten");

    // Init with steps to run enters the hash sequence
    a_init_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_init && hash_count_reg != '0) |=> (state_reg == bgv_pkg::ST_HASH_LO))
        else $error("init did not start hashing");

    // The running sum is zero after a finished stream
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_flag_next) |=> (sum_reg == '0))
        else $error("sum not cleared after last element");

endmodule
`default_nettype wire

/* tb/tb_pkg.sv */
// Testbench types for the counting Bloom vector engine checks.
// Depends on bgv_pkg for widths and the operation enum.
package tb_pkg;

    typedef struct {
        bgv_pkg::op_t                        operation;
        logic [bgv_pkg::SeedWidth-1:0]       node_id;
        logic [bgv_pkg::IndexWidth-1:0]      element_index;
        logic [bgv_pkg::CountWidth-1:0]      element_value;
        logic                                last_element;
    } bloom_item_t;

    typedef struct {
        logic [bgv_pkg::CountWidth-1:0]      stored_value;
        logic [bgv_pkg::SumWidth-1:0]        probability_sum;
        logic                                sum_valid;
    } bloom_result_t;

endpackage

/* tb/tb_if.sv */
// Note: the channel interfaces come from hdl/bgv_if.sv; this file only adds
// a small per-run knob record for idling. Depends on nothing.
interface tb_idle_if;
    logic quiet;
endinterface

/* tb/testbench.sv */
// Self-checking testbench for bloom_gradient_vector_engine_core.
// Drives directed and random init, merge, degrade and probability items,
// predicts every result from its own vector model and compares field by field.
module testbench;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [bgv_pkg::CfgIdxWidth-1:0] cfg_index;
    logic [bgv_pkg::CfgDataWidth-1:0] cfg_data;

    bgv_req_if request ();
    bgv_rsp_if response ();
    tb_idle_if idle ();

    bloom_gradient_vector_engine_core u_top (
        .clk(clk), .rst_n(rst_n), .request(request.source), .response(response.sink),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [bgv_pkg::CountWidth-1:0] local_vector [bgv_pkg::VectorSize];
    logic [bgv_pkg::SumWidth-1:0]   running_sum;
    logic [bgv_pkg::HashWidth-1:0]  hash_steps;
    logic [bgv_pkg::CountWidth-1:0] fill_value;

    tb_pkg::bloom_item_t   pending_items [$];
    tb_pkg::bloom_result_t expected_results [$];
    int            mismatch_count;
    int            idle_cycles;
    int            send_gap;
    int            recv_stall;
    bit            hold_sender;
    bit            item_taken;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Apply one accepted item to the vector model and return its result
    function automatic tb_pkg::bloom_result_t predict_result(tb_pkg::bloom_item_t it);
        tb_pkg::bloom_result_t r;
        logic [63:0] x;
        logic [16:0] wide;
        r.stored_value = '0;
        r.probability_sum = '0;
        r.sum_valid = 1'b0;
        case (it.operation)
            bgv_pkg::OP_INIT:
            begin
                foreach (local_vector[i]) local_vector[i] = '0;
                x = {32'd0, it.node_id};
                for (int s = 0; s < hash_steps; s++)
                begin
                    x = x * 64'd6364136223846793005 + 64'd1442695040888963407;
                    local_vector[x[63:32] % bgv_pkg::VectorSize] = fill_value;
                end
            end
            bgv_pkg::OP_MERGE:
            begin
                if (it.element_value > local_vector[it.element_index])
                    local_vector[it.element_index] = it.element_value;
                r.stored_value = local_vector[it.element_index];
            end
            bgv_pkg::OP_DEGRADE:
            begin
                if (it.element_value != 0 && local_vector[it.element_index] != 0)
                    local_vector[it.element_index] = local_vector[it.element_index] - 1'b1;
                r.stored_value = local_vector[it.element_index];
            end
            default:
            begin
                r.stored_value = local_vector[it.element_index];
                if (it.element_value != 0)
                begin
                    wide = running_sum + r.stored_value;
                    running_sum = wide[16] ? 16'hFFFF : wide[15:0];
                end
                if (it.last_element)
                begin
                    r.probability_sum = running_sum;
                    r.sum_valid = 1'b1;
                    running_sum = '0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    function automatic tb_pkg::bloom_item_t make_item(bgv_pkg::op_t op, logic [31:0] id,
                                                      logic [7:0] ix, logic [7:0] v,
                                                      logic l);
        tb_pkg::bloom_item_t it;
        it.operation = op;
        it.node_id = id;
        it.element_index = ix;
        it.element_value = v;
        it.last_element = l;
        return it;
    endfunction

    function automatic tb_pkg::bloom_item_t random_item();
        int pick;
        bgv_pkg::op_t op;
        logic [7:0] ix;
        pick = $urandom_range(0, 99);
        if (pick < 4) op = bgv_pkg::OP_INIT;
        else if (pick < 40) op = bgv_pkg::OP_MERGE;
        else if (pick < 55) op = bgv_pkg::OP_DEGRADE;
        else op = bgv_pkg::OP_PROB;
        // Keep indexes in a small window at times so merges and reads collide
        ix = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        return make_item(op, $urandom, ix,
                         ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom),
                         ($urandom_range(0, 5) == 0));
    endfunction

    task automatic write_register(input bgv_pkg::cfg_idx_t which, input logic [7:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (which == bgv_pkg::CFG_HASH_COUNT) hash_steps = value[bgv_pkg::HashWidth-1:0];
        else fill_value = value;
    endtask

    // Wait until all results are back, then let a worst-case init finish
    task automatic drain_block();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    // Note whether the presented item was taken at the last rising edge
    always @(posedge clk)
    begin
        item_taken <= request.valid && request.ready;
    end

    // Driver: present items at the falling edge, idle in random bursts
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request.valid <= 1'b0;
            request.operation <= bgv_pkg::OP_INIT;
            request.node_id <= '0;
            request.element_index <= '0;
            request.element_value <= '0;
            request.last_element <= 1'b0;
            send_gap <= 0;
        end
        else if (!request.valid || item_taken)
        begin
            if (send_gap > 0 || hold_sender || pending_items.size() == 0)
            begin
                request.valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end
            else if (!idle.quiet && $urandom_range(0, 5) == 0)
            begin
                request.valid <= 1'b0;
                send_gap <= $urandom_range(0, 9);
            end
            else
            begin
                request.valid <= 1'b1;
                request.operation <= pending_items[0].operation;
                request.node_id <= pending_items[0].node_id;
                request.element_index <= pending_items[0].element_index;
                request.element_value <= pending_items[0].element_value;
                request.last_element <= pending_items[0].last_element;
                void'(pending_items.pop_front());
            end
        end
    end

    // Receiver readiness: stall in random bursts
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            response.ready <= 1'b0;
            recv_stall <= 0;
        end
        else if (recv_stall > 0)
        begin
            response.ready <= 1'b0;
            recv_stall <= recv_stall - 1;
        end
        else if (!idle.quiet && $urandom_range(0, 5) == 0)
        begin
            response.ready <= 1'b0;
            recv_stall <= $urandom_range(0, 9);
        end
        else
            response.ready <= 1'b1;
    end

    // Monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        tb_pkg::bloom_item_t it;
        tb_pkg::bloom_result_t want;
        if (rst_n)
        begin
            if (request.valid && request.ready)
            begin
                it = make_item(bgv_pkg::op_t'(request.operation), request.node_id,
                               request.element_index, request.element_value,
                               request.last_element);
                expected_results.push_back(predict_result(it));
            end
            if (response.valid && response.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", response.stored_value, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (response.stored_value !== want.stored_value)
                        report_mismatch("stored_value", response.stored_value,
                                        want.stored_value);
                    if (response.probability_sum !== want.probability_sum)
                        report_mismatch("probability_sum", response.probability_sum,
                                        want.probability_sum);
                    if (response.sum_valid !== want.sum_valid)
                        report_mismatch("sum_valid", response.sum_valid, want.sum_valid);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (request.valid && request.ready) || (response.valid && response.ready)
            || (pending_items.size() == 0 && expected_results.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= 5000)
        begin
            $display("bloom_gradient_vector_engine_core: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [7:0] hash_set [4];
        logic [7:0] fill_set [4];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle.quiet = 1'b0;
        hold_sender = 1'b0;
        mismatch_count = 0;
        running_sum = '0;
        hash_steps = bgv_pkg::HASH_COUNT_RESET;
        fill_value = bgv_pkg::FILL_LEVEL_RESET;
        foreach (local_vector[i]) local_vector[i] = '0;
        hash_set = '{8'd0, 8'd16, 8'd31, 8'd1};
        fill_set = '{8'd0, 8'd255, 8'd1, 8'd128};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, extremes, stream finish
        pending_items.push_back(make_item(bgv_pkg::OP_PROB, 0, 8'd3, 8'd1, 1'b1));
        pending_items.push_back(make_item(bgv_pkg::OP_INIT, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0));
        pending_items.push_back(make_item(bgv_pkg::OP_MERGE, 0, 8'd255, 8'd255, 1'b0));
        pending_items.push_back(make_item(bgv_pkg::OP_MERGE, 0, 8'd0, 8'd0, 1'b0));
        pending_items.push_back(make_item(bgv_pkg::OP_MERGE, 0, 8'd1, 8'hAA, 1'b1));
        pending_items.push_back(make_item(bgv_pkg::OP_MERGE, 0, 8'd1, 8'h55, 1'b0));
        pending_items.push_back(make_item(bgv_pkg::OP_DEGRADE, 0, 8'd1, 8'd0, 1'b0));
        pending_items.push_back(make_item(bgv_pkg::OP_DEGRADE, 0, 8'd1, 8'd255, 1'b0));
        pending_items.push_back(make_item(bgv_pkg::OP_DEGRADE, 0, 8'd2, 8'd1, 1'b0));
        for (int i = 0; i < 12; i++)
            pending_items.push_back(make_item(bgv_pkg::OP_MERGE, 0, 8'(i), 8'd255, 1'b0));
        hold_sender = 1'b0;
        drain_block();
        // Full stream over the low counters, then an empty stream
        for (int i = 0; i < 32; i++)
            pending_items.push_back(make_item(bgv_pkg::OP_PROB, 0, 8'(i), 8'd200, i == 31));
        pending_items.push_back(make_item(bgv_pkg::OP_PROB, 0, 8'd0, 8'd0, 1'b1));
        drain_block();

        // Random phases under several register settings
        for (int ph = 0; ph < 4; ph++)
        begin
            write_register(bgv_pkg::CFG_HASH_COUNT, hash_set[ph]);
            write_register(bgv_pkg::CFG_FILL_LEVEL, fill_set[ph]);
            pending_items.push_back(make_item(bgv_pkg::OP_INIT, $urandom, 8'd0, 8'd0, 1'b0));
            if (ph == 3) idle.quiet = 1'b1;
            for (int n = 0; n < 95; n++)
                pending_items.push_back(random_item());
            if (ph == 1)
            begin
                // Let the sender sit until every result is back
                while (pending_items.size() > 50) @(negedge clk);
                hold_sender = 1'b1;
                while (expected_results.size() != 0) @(negedge clk);
                hold_sender = 1'b0;
            end
            drain_block();
        end

        if (mismatch_count == 0)
            $display("bloom_gradient_vector_engine_core: match");
        else
            $display("bloom_gradient_vector_engine_core: mismatch");
        $finish;
    end

endmodule
